// File: rtl/uart_bds_pkg.sv
package uart_bds_pkg;

  localparam int unsigned OsrMax   = 32;
  localparam int unsigned RatioMin = 4;
  localparam int unsigned RatioDef = 16;
  localparam int unsigned DivDef   = 4;
  localparam int unsigned PctBase  = 100;

  localparam int unsigned WordW  = 32;
  localparam int unsigned RatioW = 6;
  localparam int unsigned DivW   = 16;
  localparam int unsigned CntW   = $clog2(WordW);

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadErr = 2'd1,
    StInvalid = 2'd2
  } status_e;

  typedef struct packed {
    logic [WordW-1:0] clock_hz;
    logic [WordW-1:0] target_baud;
  } in_t;

  typedef struct packed {
    logic [RatioW-1:0] oversample_ratio;
    logic [DivW-1:0]   rate_divisor;
    status_e           status;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] num;
    logic [WordW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/uart_bds_in_if.sv
interface uart_bds_in_if import uart_bds_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/uart_bds_out_if.sv
interface uart_bds_out_if import uart_bds_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/uart_baud_divisor_search.sv
// Channel  Dir  Payload                                     Beat
// in_i     in   clock_hz, target_baud                       valid & ready
// out_o    out  oversample_ratio, rate_divisor, status      valid & ready
//
// One beat in, one beat out. Baud zero answers without any trial.
// Otherwise each ratio trial takes 3 divisions plus setup; up to 29
// trials are run, plus a final baud/100 division. All divisions use
// the shared 32-bit serial divider.
// in_i.ready is high only while idle; a result held on a stalled out_o
// does not block the next input beat. Reset is asynchronous, active low.
module uart_baud_divisor_search import uart_bds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  uart_bds_in_if.sink     in_i,
  uart_bds_out_if.source  out_o
);

  typedef enum logic [2:0] {
    SIdle,
    SMul,
    SDiv,
    SCmp,
    SOut
  } state_e;

  typedef enum logic [1:0] {
    PhDiv,
    PhLo,
    PhHi,
    PhLim
  } phase_e;

  state_e            state_q;
  phase_e            ph_q;
  logic              start_q;
  logic [WordW-1:0]  clk_q, baud_q, den_q, num_q;
  logic [RatioW-1:0] r_q;
  logic [DivW-1:0]   d_q;
  logic [WordW-1:0]  err_q, errup_q, best_err_q;
  logic [RatioW-1:0] best_ratio_q;
  logic [DivW-1:0]   best_div_q;
  status_e           res_status_q;
  logic              out_valid_q;
  out_t              out_data_q;

  logic [DivW:0]          d_inc;
  logic [WordW-1:0]       mul_a;
  logic [WordW+RatioW-1:0] prod;
  logic [WordW-1:0]       sel_err;
  logic [DivW-1:0]        sel_div;
  logic                   better;
  logic [WordW-1:0]       new_best;
  logic [WordW-1:0]       lim;
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic                   in_acc;

  assign in_acc = in_i.valid && in_i.ready;
  assign d_inc  = {1'b0, d_q} + (DivW+1)'(1);

  always_comb begin
    unique case (ph_q)
      PhDiv:   mul_a = baud_q;
      PhLo:    mul_a = {{(WordW-DivW){1'b0}}, d_q};
      PhHi:    mul_a = {{(WordW-DivW-1){1'b0}}, d_inc};
      default: mul_a = '0;
    endcase
  end

  assign prod = {{RatioW{1'b0}}, mul_a} * {{WordW{1'b0}}, r_q};

  assign better   = (err_q > errup_q);
  assign sel_err  = better ? errup_q : err_q;
  assign sel_div  = better ? d_inc[DivW-1:0] : d_q;
  assign new_best = (sel_err < best_err_q) ? sel_err : best_err_q;
  assign lim      = div_rsp.quot + {div_rsp.quot[WordW-2:0], 1'b0};

  assign div_req.start = start_q;
  assign div_req.num   = num_q;
  assign div_req.den   = den_q;

  uart_bds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      ph_q        <= PhDiv;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= (state_q == SMul);
      if (out_valid_q && out_o.ready && state_q != SOut) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (in_acc) begin
            clk_q        <= in_i.data.clock_hz;
            baud_q       <= in_i.data.target_baud;
            r_q          <= RatioW'(OsrMax);
            best_ratio_q <= RatioW'(RatioDef);
            best_div_q   <= DivW'(DivDef);
            best_err_q   <= in_i.data.target_baud;
            ph_q         <= PhDiv;
            if (in_i.data.target_baud == '0) begin
              res_status_q <= StInvalid;
              state_q      <= SOut;
            end else begin
              state_q <= SMul;
            end
          end
        end
        SMul: begin
          if (ph_q == PhLim) begin
            num_q <= baud_q;
            den_q <= WordW'(PctBase);
          end else begin
            num_q <= clk_q;
            den_q <= prod[WordW-1:0];
          end
          state_q <= SDiv;
        end
        SDiv: begin
          if (div_rsp.done) begin
            unique case (ph_q)
              PhDiv: begin
                d_q     <= (div_rsp.quot[DivW-1:0] == '0) ? DivW'(1)
                                                          : div_rsp.quot[DivW-1:0];
                ph_q    <= PhLo;
                state_q <= SMul;
              end
              PhLo: begin
                err_q   <= div_rsp.quot - baud_q;
                ph_q    <= PhHi;
                state_q <= SMul;
              end
              PhHi: begin
                errup_q <= baud_q - div_rsp.quot;
                state_q <= SCmp;
              end
              default: begin
                res_status_q <= (best_err_q > lim) ? StBadErr : StOk;
                state_q      <= SOut;
              end
            endcase
          end
        end
        SCmp: begin
          if (sel_err < best_err_q) begin
            best_err_q   <= sel_err;
            best_ratio_q <= r_q;
            best_div_q   <= sel_div;
          end
          if (new_best == '0 || r_q == RatioW'(RatioMin)) begin
            ph_q <= PhLim;
          end else begin
            r_q  <= r_q - RatioW'(1);
            ph_q <= PhDiv;
          end
          state_q <= SMul;
        end
        default: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q                 <= 1'b1;
            out_data_q.oversample_ratio <= best_ratio_q;
            out_data_q.rate_divisor     <= best_div_q;
            out_data_q.status           <= res_status_q;
            state_q                     <= SIdle;
          end
        end
      endcase
    end
  end

  assign in_i.ready  = (state_q == SIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// File: rtl/uart_bds_div.sv
// restoring divider, one quotient bit per cycle; den zero gives all ones
module uart_bds_div import uart_bds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW-1:0] quo_q, quo_d;
  logic [WordW-1:0] den_q, den_d;
  logic [WordW:0]   trial;
  logic [WordW:0]   diff;
  logic             bit_ok;

  assign trial  = {rem_q, quo_q[WordW-1]};
  assign diff   = trial - {1'b0, den_q};
  assign bit_ok = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = bit_ok ? diff[WordW-1:0] : trial[WordW-1:0];
      quo_d = {quo_q[WordW-2:0], bit_ok};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// File: rtl/uart_bds_chk.sv
module uart_bds_chk import uart_bds_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input in_t  in_data_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.oversample_ratio >= RatioW'(RatioMin) &&
                    out_data_i.oversample_ratio <= RatioW'(OsrMax))
    else $error("ratio out of range");

  a_invalid_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == StInvalid |->
      out_data_i.oversample_ratio == RatioW'(RatioDef) &&
      out_data_i.rate_divisor == DivW'(DivDef))
    else $error("invalid result without defaults");

  a_zero_baud_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_data_i.target_baud == '0 && !out_valid_i
      |=> ##1 out_valid_i && out_data_i.status == StInvalid)
    else $error("zero baud not flagged");

endmodule

bind uart_baud_divisor_search uart_bds_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_data_i   (in_i.data),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
